// ----- src/scanline_interrupt_tape_controller_macros.svh -----
// ----------------------------------------------------------------------------
// scanline interrupt tape controller assertion macros
// shared assertion forms, clocked on the rising edge, off while in reset
// ----------------------------------------------------------------------------
`ifndef SCANLINE_INTERRUPT_TAPE_CONTROLLER_MACROS_SVH
`define SCANLINE_INTERRUPT_TAPE_CONTROLLER_MACROS_SVH

// property that must hold at every edge out of reset
`define SITC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// non-overlapping implication check
`define SITC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/sitc_pkg.sv -----
// ----------------------------------------------------------------------------
// sitc_pkg
// types and register codes shared by the scanline interrupt tape controller
// ----------------------------------------------------------------------------
package sitc_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  localparam logic [3:0] REG_STATUS  = 4'h0;
  localparam logic [3:0] REG_DATA    = 4'h4;
  localparam logic [3:0] REG_PAGE    = 4'h5;
  localparam logic [3:0] REG_CONTROL = 4'h7;

  localparam logic [1:0] TAPE_DATA = 2'd0;
  localparam logic [1:0] TAPE_TONE = 2'd1;
  localparam logic [1:0] TAPE_END  = 2'd2;

  localparam logic [1:0] OUT_DATA    = 2'd0;
  localparam logic [1:0] OUT_TONE    = 2'd1;
  localparam logic [1:0] OUT_SILENCE = 2'd2;

  localparam logic [6:0] ST_POWERON  = 7'h02;
  localparam logic [6:0] ST_DISPEND  = 7'h04;
  localparam logic [6:0] ST_TIMER    = 7'h08;
  localparam logic [6:0] ST_RECEIVE  = 7'h10;
  localparam logic [6:0] ST_TRANSMIT = 7'h20;
  localparam logic [6:0] ST_HIGHTONE = 7'h40;
  localparam logic [6:0] ST_SOURCES  = 7'h7c;

  localparam logic [7:0] READ_MARK       = 8'h80;
  localparam logic [7:0] CTRL_MODE_MASK  = 8'h06;
  localparam logic [7:0] CTRL_MODE_WRITE = 8'h04;
  localparam logic [7:0] CTRL_MODE_READ  = 8'h00;
  localparam logic [7:0] CTRL_MOTOR      = 8'h40;
  localparam logic [7:0] PAGE_MASK       = 8'h0f;

  localparam logic [7:0] CLR_HIGHTONE = 8'h40;
  localparam logic [7:0] CLR_TIMER    = 8'h20;
  localparam logic [7:0] CLR_DISPEND  = 8'h10;

  localparam logic [3:0] PAGE_LOCK_LO = 4'd8;
  localparam logic [3:0] PAGE_LOCK_HI = 4'd11;

  typedef struct packed {
    op_e        operation;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [1:0] tape_kind;
    logic [7:0] tape_byte;
  } item_t;

  typedef struct packed {
    logic [6:0] irq_status;
    logic [7:0] irq_enable;
    logic [7:0] cassette_data;
    logic [7:0] control_reg;
    logic [3:0] page_select;
    logic       out_has_data;
    logic [8:0] line_count;
    logic [7:0] tape_divider;
    logic       irq_out;
  } state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_from_rom;
    logic       irq_line;
    logic [3:0] rom_page;
    logic [8:0] current_line;
    logic       tape_taken;
    logic       tape_out_valid;
    logic [1:0] tape_out_kind;
    logic [7:0] tape_out_byte;
  } result_t;

endpackage

// ----- src/sitc_core.sv -----
// ----------------------------------------------------------------------------
// sitc_core
// next register state and result for one access or scanline tick
// ----------------------------------------------------------------------------
module sitc_core import sitc_pkg::*; #(
  parameter int LAST_LINE           = 312,
  parameter int END_LINE            = 256,
  parameter int TIMER_LINE          = 100,
  parameter int LINES_PER_TAPE_BYTE = 130
) (
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  function automatic state_t raise_irq(state_t s, logic [6:0] bits);
    state_t t;
    t = s;
    t.irq_status = t.irq_status | bits;
    if ((t.irq_enable[6:0] & bits) != 7'h00) begin
      t.irq_out = 1'b1;
    end
    return t;
  endfunction

  function automatic state_t drop_irq(state_t s, logic [6:0] bits);
    state_t t;
    t = s;
    t.irq_status = t.irq_status & ~bits;
    if ((t.irq_status & t.irq_enable[6:0]) == 7'h00) begin
      t.irq_out = 1'b0;
    end
    return t;
  endfunction

  always_comb begin
    state_t     s;
    result_t    r;
    logic [9:0] next_line;
    logic [8:0] next_div;
    logic [6:0] mask;
    logic [7:0] v;
    logic [7:0] page_bits;
    s         = state_i;
    r         = '0;
    next_line = '0;
    next_div  = '0;
    mask      = '0;
    v         = item_i.write_data;
    page_bits = v & PAGE_MASK;
    case (item_i.operation)
      OP_READ: begin
        case (item_i.reg_index)
          REG_STATUS: begin
            r.read_data = READ_MARK | {1'b0, s.irq_status[6:1], 1'b0}
                          | {7'h00, |(s.irq_enable[6:0] & s.irq_status & ST_SOURCES)};
            s.irq_status = s.irq_status & ~ST_POWERON;
          end
          REG_DATA: begin
            s = drop_irq(s, ST_RECEIVE);
            r.read_data = s.cassette_data;
          end
          default: begin
            r.read_from_rom = 1'b1;
          end
        endcase
      end
      OP_WRITE: begin
        case (item_i.reg_index)
          REG_STATUS: begin
            s.irq_enable = v & ~{1'b0, ST_POWERON};
          end
          REG_DATA: begin
            s.cassette_data = v;
            s = drop_irq(s, ST_TRANSMIT);
            s.out_has_data = 1'b1;
          end
          REG_PAGE: begin
            if (!(s.page_select inside {[PAGE_LOCK_LO:PAGE_LOCK_HI]})
                || (v[3:0] >= PAGE_LOCK_LO)) begin
              s.page_select = page_bits[3:0];
            end
            if ((v & CLR_HIGHTONE) != 8'h00) mask = mask | ST_HIGHTONE;
            if ((v & CLR_TIMER) != 8'h00) mask = mask | ST_TIMER;
            if ((v & CLR_DISPEND) != 8'h00) mask = mask | ST_DISPEND;
            s = drop_irq(s, mask);
          end
          REG_CONTROL: begin
            s.control_reg = v;
            if (((state_i.control_reg & CTRL_MODE_MASK) != CTRL_MODE_WRITE)
                && ((v & CTRL_MODE_MASK) == CTRL_MODE_WRITE)) begin
              s.out_has_data = 1'b0;
              s = raise_irq(s, ST_TRANSMIT);
            end
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        next_line = {1'b0, s.line_count} + 10'd1;
        if (next_line > 10'(LAST_LINE)) begin
          next_line = '0;
        end
        s.line_count = next_line[8:0];
        if (s.line_count < 9'(END_LINE)) begin
          if (s.line_count == 9'(TIMER_LINE)) begin
            s = raise_irq(s, ST_TIMER);
          end
        end else if (s.line_count == 9'(END_LINE)) begin
          s = raise_irq(s, ST_DISPEND);
        end

        next_div = {1'b0, s.tape_divider} + 9'd1;
        if (next_div >= 9'(LINES_PER_TAPE_BYTE)) begin
          s.tape_divider = '0;
          if ((s.control_reg & CTRL_MOTOR) != 8'h00) begin
            if ((s.control_reg & CTRL_MODE_MASK) == CTRL_MODE_WRITE) begin
              r.tape_out_valid = 1'b1;
              if (s.out_has_data) begin
                r.tape_out_kind = OUT_DATA;
                r.tape_out_byte = s.cassette_data;
                s.out_has_data = 1'b0;
                s = raise_irq(s, ST_TRANSMIT);
              end else begin
                r.tape_out_kind = OUT_TONE;
              end
            end else if (item_i.tape_kind >= TAPE_END) begin
              r.tape_out_valid = 1'b1;
              r.tape_out_kind = OUT_SILENCE;
              s = drop_irq(s, ST_HIGHTONE);
            end else begin
              r.tape_taken = 1'b1;
              if (item_i.tape_kind == TAPE_TONE) begin
                s = raise_irq(s, ST_HIGHTONE);
              end else begin
                s = drop_irq(s, ST_HIGHTONE);
                if ((s.control_reg & CTRL_MODE_MASK) == CTRL_MODE_READ) begin
                  s.cassette_data = item_i.tape_byte;
                  s = raise_irq(s, ST_RECEIVE);
                end
              end
            end
          end
        end else begin
          s.tape_divider = next_div[7:0];
        end
      end
      default: begin
      end
    endcase
    r.irq_line     = s.irq_out;
    r.rom_page     = s.page_select;
    r.current_line = s.line_count;
    state_o  = s;
    result_o = r;
  end

endmodule

// ----- src/scanline_interrupt_tape_controller.sv -----
// ----------------------------------------------------------------------------
// scanline_interrupt_tape_controller
// system chip register block: interrupts, rom paging, scanline and tape timing
// ----------------------------------------------------------------------------
// One word in, one word out: each register read, register write or scanline
// tick yields exactly one result word. Each word is held in the input
// register, is worked through the register update logic, and is written into
// the result register, from which its result is offered. Throughput is one
// word per cycle while the result register is not stalled downstream; a word
// waits in the input register, and new words are refused, while a held result
// is stalled. No clearing pass follows reset: the valid flags and chip state
// reset at once, while the item and result registers are not reset.
module scanline_interrupt_tape_controller import sitc_pkg::*; #(
  parameter int LAST_LINE           = 312,
  parameter int END_LINE            = 256,
  parameter int TIMER_LINE          = 100,
  parameter int LINES_PER_TAPE_BYTE = 130,
  parameter int BASIC_PAGE          = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic [1:0] tape_kind_i,
  input  logic [7:0] tape_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       read_from_rom_o,
  output logic       irq_line_o,
  output logic [3:0] rom_page_o,
  output logic [8:0] current_line_o,
  output logic       tape_taken_o,
  output logic       tape_out_valid_o,
  output logic [1:0] tape_out_kind_o,
  output logic [7:0] tape_out_byte_o
);

`include "scanline_interrupt_tape_controller_macros.svh"

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  logic    advance;
  logic    in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  sitc_core #(
    .LAST_LINE          (LAST_LINE),
    .END_LINE           (END_LINE),
    .TIMER_LINE         (TIMER_LINE),
    .LINES_PER_TAPE_BYTE(LINES_PER_TAPE_BYTE)
  ) u_core (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{
        irq_status:    ST_POWERON,
        irq_enable:    8'h00,
        cassette_data: 8'h00,
        control_reg:   8'h00,
        page_select:   4'(BASIC_PAGE),
        out_has_data:  1'b0,
        line_count:    9'h000,
        tape_divider:  8'h00,
        irq_out:       1'b0
      };
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{
        operation:  op_e'(operation_i),
        reg_index:  reg_index_i,
        write_data: write_data_i,
        tape_kind:  tape_kind_i,
        tape_byte:  tape_byte_i
      };
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = result_q.read_data;
  assign read_from_rom_o  = result_q.read_from_rom;
  assign irq_line_o       = result_q.irq_line;
  assign rom_page_o       = result_q.rom_page;
  assign current_line_o   = result_q.current_line;
  assign tape_taken_o     = result_q.tape_taken;
  assign tape_out_valid_o = result_q.tape_out_valid;
  assign tape_out_kind_o  = result_q.tape_out_kind;
  assign tape_out_byte_o  = result_q.tape_out_byte;

  `SITC_ASSERT(a_line_in_frame, clk_i, rst_ni, state_q.line_count <= 9'(LAST_LINE), "line past frame end")
  `SITC_ASSERT(a_div_in_range, clk_i, rst_ni, {1'b0, state_q.tape_divider} < 9'(LINES_PER_TAPE_BYTE), "tape divider overrun")
  `SITC_ASSERT(a_no_overwrite, clk_i, rst_ni, !(out_valid_q && out_stall_i && advance), "result overwritten while stalled")
  `SITC_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_accept, in_valid_q, "accepted word lost")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives register reads, writes and scanline ticks into the scanline
// interrupt tape controller with random idling on both channels outside the
// calm stretch, predicts every result word from a behavioural copy of the
// chip registers and compares each accepted word whole against it in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sitc_pkg::*;

  localparam int LAST_LINE           = 312;
  localparam int END_LINE            = 256;
  localparam int TIMER_LINE          = 100;
  localparam int LINES_PER_TAPE_BYTE = 130;
  localparam int BASIC_PAGE          = 10;

  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam logic [1:0] TAPE_SPARE    = 2'd3;
  localparam logic [3:0] REG_UNUSED    = 4'h1;
  localparam logic [3:0] REG_LAST_SLOT = 4'hf;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_WORDS    = 250;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] operation_i = '0;
  logic [3:0] reg_index_i = '0;
  logic [7:0] write_data_i = '0;
  logic [1:0] tape_kind_i = '0;
  logic [7:0] tape_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       read_from_rom_o;
  logic       irq_line_o;
  logic [3:0] rom_page_o;
  logic [8:0] current_line_o;
  logic       tape_taken_o;
  logic       tape_out_valid_o;
  logic [1:0] tape_out_kind_o;
  logic [7:0] tape_out_byte_o;

  bit calm_phase = 1'b0;
  int quiet_cycles = 0;

  class chip_register_scoreboard;
    state_t  regs;
    result_t pending_results[$];
    int      mismatches;

    function new();
      regs             = '0;
      regs.irq_status  = ST_POWERON;
      regs.page_select = 4'(BASIC_PAGE);
      mismatches       = 0;
    endfunction

    function void raise_status(logic [6:0] bits);
      regs.irq_status |= bits;
      if ((regs.irq_enable[6:0] & bits) != '0) regs.irq_out = 1'b1;
    endfunction

    function void clear_status(logic [6:0] bits);
      regs.irq_status &= ~bits;
      if ((regs.irq_status & regs.irq_enable[6:0]) == '0) regs.irq_out = 1'b0;
    endfunction

    function void note_word(logic [1:0] op, logic [3:0] idx, logic [7:0] data,
                            logic [1:0] kind, logic [7:0] tbyte);
      result_t     exp;
      logic [7:0]  old_ctrl;
      logic [6:0]  clr;
      int unsigned next_line;
      int unsigned next_div;
      exp = '0;
      if (op == OP_READ) begin
        if (idx == REG_STATUS) begin
          exp.read_data = READ_MARK | {1'b0, regs.irq_status[6:1], 1'b0};
          if ((regs.irq_enable[6:0] & regs.irq_status & ST_SOURCES) != '0)
            exp.read_data[0] = 1'b1;
          regs.irq_status &= ~ST_POWERON;
        end else if (idx == REG_DATA) begin
          clear_status(ST_RECEIVE);
          exp.read_data = regs.cassette_data;
        end else begin
          exp.read_from_rom = 1'b1;
        end
      end else if (op == OP_WRITE) begin
        if (idx == REG_STATUS) begin
          regs.irq_enable = data & ~{1'b0, ST_POWERON};
        end else if (idx == REG_DATA) begin
          regs.cassette_data = data;
          clear_status(ST_TRANSMIT);
          regs.out_has_data = 1'b1;
        end else if (idx == REG_PAGE) begin
          if (regs.page_select < PAGE_LOCK_LO || regs.page_select > PAGE_LOCK_HI ||
              data[3:0] >= PAGE_LOCK_LO)
            regs.page_select = data[3:0];
          clr = '0;
          if ((data & CLR_HIGHTONE) != '0) clr |= ST_HIGHTONE;
          if ((data & CLR_TIMER) != '0) clr |= ST_TIMER;
          if ((data & CLR_DISPEND) != '0) clr |= ST_DISPEND;
          clear_status(clr);
        end else if (idx == REG_CONTROL) begin
          old_ctrl = regs.control_reg;
          regs.control_reg = data;
          if ((old_ctrl & CTRL_MODE_MASK) != CTRL_MODE_WRITE &&
              (data & CTRL_MODE_MASK) == CTRL_MODE_WRITE) begin
            regs.out_has_data = 1'b0;
            raise_status(ST_TRANSMIT);
          end
        end
      end else if (op == OP_TICK) begin
        next_line = regs.line_count + 1;
        if (next_line > LAST_LINE) next_line = 0;
        regs.line_count = next_line[8:0];
        if (regs.line_count < END_LINE) begin
          if (regs.line_count == TIMER_LINE) raise_status(ST_TIMER);
        end else if (regs.line_count == END_LINE) begin
          raise_status(ST_DISPEND);
        end
        next_div = regs.tape_divider + 1;
        if (next_div >= LINES_PER_TAPE_BYTE) begin
          next_div = 0;
          if ((regs.control_reg & CTRL_MOTOR) != '0) begin
            if ((regs.control_reg & CTRL_MODE_MASK) == CTRL_MODE_WRITE) begin
              exp.tape_out_valid = 1'b1;
              if (regs.out_has_data) begin
                exp.tape_out_kind = OUT_DATA;
                exp.tape_out_byte = regs.cassette_data;
                regs.out_has_data = 1'b0;
                raise_status(ST_TRANSMIT);
              end else begin
                exp.tape_out_kind = OUT_TONE;
              end
            end else if (kind >= TAPE_END) begin
              exp.tape_out_valid = 1'b1;
              exp.tape_out_kind  = OUT_SILENCE;
              clear_status(ST_HIGHTONE);
            end else begin
              exp.tape_taken = 1'b1;
              if (kind == TAPE_TONE) begin
                raise_status(ST_HIGHTONE);
              end else begin
                clear_status(ST_HIGHTONE);
                if ((regs.control_reg & CTRL_MODE_MASK) == CTRL_MODE_READ) begin
                  regs.cassette_data = tbyte;
                  raise_status(ST_RECEIVE);
                end
              end
            end
          end
        end
        regs.tape_divider = next_div[7:0];
      end
      exp.irq_line     = regs.irq_out;
      exp.rom_page     = regs.page_select;
      exp.current_line = regs.line_count;
      pending_results.push_back(exp);
    endfunction

    function string describe(result_t r);
      return $sformatf("data %h rom %b irq %b page %h line %0d taken %b out %b kind %0d byte %h",
                       r.read_data, r.read_from_rom, r.irq_line, r.rom_page, r.current_line,
                       r.tape_taken, r.tape_out_valid, r.tape_out_kind, r.tape_out_byte);
    endfunction

    function void check_word(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: %s", describe(got));
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (got !== exp) begin
        if (mismatches < 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  chip_register_scoreboard board = new();

  scanline_interrupt_tape_controller #(
    .LAST_LINE           (LAST_LINE),
    .END_LINE            (END_LINE),
    .TIMER_LINE          (TIMER_LINE),
    .LINES_PER_TAPE_BYTE (LINES_PER_TAPE_BYTE),
    .BASIC_PAGE          (BASIC_PAGE)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .reg_index_i      (reg_index_i),
    .write_data_i     (write_data_i),
    .tape_kind_i      (tape_kind_i),
    .tape_byte_i      (tape_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .read_from_rom_o  (read_from_rom_o),
    .irq_line_o       (irq_line_o),
    .rom_page_o       (rom_page_o),
    .current_line_o   (current_line_o),
    .tape_taken_o     (tape_taken_o),
    .tape_out_valid_o (tape_out_valid_o),
    .tape_out_kind_o  (tape_out_kind_o),
    .tape_out_byte_o  (tape_out_byte_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !calm_phase && ($urandom_range(99) < 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      board.note_word(operation_i, reg_index_i, write_data_i, tape_kind_i, tape_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word({read_data_o, read_from_rom_o, irq_line_o, rom_page_o,
                        current_line_o, tape_taken_o, tape_out_valid_o,
                        tape_out_kind_o, tape_out_byte_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic [7:0] data, input logic [1:0] kind,
                           input logic [7:0] tbyte);
    while (!calm_phase && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    reg_index_i  <= idx;
    write_data_i <= data;
    tape_kind_i  <= kind;
    tape_byte_i  <= tbyte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    int unsigned roll;
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  tbyte;
    roll  = $urandom_range(99);
    pick  = $urandom_range(99);
    data  = 8'($urandom);
    tbyte = 8'($urandom);
    if (roll < 50) kind = TAPE_DATA;
    else if (roll < 75) kind = TAPE_TONE;
    else if (roll < 94) kind = TAPE_END;
    else kind = TAPE_SPARE;
    if (pick < 70) begin
      send_word(OP_TICK, 4'($urandom), data, kind, tbyte);
    end else if (pick < 76) begin
      send_word(OP_READ, REG_STATUS, data, kind, tbyte);
    end else if (pick < 80) begin
      send_word(OP_READ, REG_DATA, data, kind, tbyte);
    end else if (pick < 83) begin
      send_word(OP_READ, 4'($urandom), data, kind, tbyte);
    end else if (pick < 87) begin
      send_word(OP_WRITE, REG_STATUS, data, kind, tbyte);
    end else if (pick < 91) begin
      send_word(OP_WRITE, REG_DATA, data, kind, tbyte);
    end else if (pick < 96) begin
      send_word(OP_WRITE, REG_PAGE, data, kind, tbyte);
    end else if (pick < 98) begin
      // motor mostly left running so tape words keep moving
      if ($urandom_range(9) < 8) data = data | CTRL_MOTOR;
      send_word(OP_WRITE, REG_CONTROL, data, kind, tbyte);
    end else if (pick < 99) begin
      send_word(OP_WRITE, 4'($urandom), data, kind, tbyte);
    end else begin
      send_word(OP_SPARE, 4'($urandom), data, kind, tbyte);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // power-on bit shows on the first status read only
    send_word(OP_READ,  REG_STATUS,    8'h00, TAPE_DATA,  8'h00);
    send_word(OP_READ,  REG_STATUS,    8'hff, TAPE_END,   8'hff);
    send_word(OP_READ,  REG_DATA,      8'h00, TAPE_TONE,  8'h00);
    send_word(OP_READ,  REG_LAST_SLOT, 8'h00, TAPE_SPARE, 8'h00);
    send_word(OP_WRITE, REG_STATUS,    8'hff, TAPE_DATA,  8'hff);
    // basic page locked against low pages
    send_word(OP_WRITE, REG_PAGE,      8'h03, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_PAGE,      8'h0f, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_PAGE,      8'h00, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_PAGE,      8'h78, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_PAGE,      8'h07, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_CONTROL,   CTRL_MOTOR | CTRL_MODE_WRITE, TAPE_DATA, 8'h00);
    send_word(OP_READ,  REG_STATUS,    8'h00, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_DATA,      8'hff, TAPE_DATA,  8'h00);
    send_word(OP_READ,  REG_DATA,      8'h00, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_UNUSED,    8'haa, TAPE_DATA,  8'h55);
    send_word(OP_SPARE, REG_STATUS,    8'h55, TAPE_SPARE, 8'haa);
    send_word(OP_TICK,  REG_LAST_SLOT, 8'hff, TAPE_SPARE, 8'hff);
    send_word(OP_WRITE, REG_CONTROL,   8'hff, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_CONTROL,   CTRL_MODE_READ, TAPE_DATA, 8'h00);
    send_word(OP_WRITE, REG_STATUS,    8'h00, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_PAGE,      8'h70, TAPE_DATA,  8'h00);
    send_word(OP_WRITE, REG_STATUS,    8'h7c, TAPE_DATA,  8'h00);

    // receive, then transmit in the calm stretch, then free running
    send_word(OP_WRITE, REG_CONTROL, CTRL_MOTOR | CTRL_MODE_READ, TAPE_DATA, 8'h00);
    repeat (PHASE_WORDS) send_random_word();
    calm_phase = 1'b1;
    send_word(OP_WRITE, REG_CONTROL, CTRL_MOTOR | CTRL_MODE_WRITE, TAPE_DATA, 8'h00);
    repeat (PHASE_WORDS) send_random_word();
    calm_phase = 1'b0;
    repeat (PHASE_WORDS) send_random_word();
    in_valid_i <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/sitc_pkg.sv
src/sitc_core.sv
src/scanline_interrupt_tape_controller.sv
dv/testbench.sv
